@@ hw/rtl/ppfd_pkg.sv @@
// Package for the parking-sensor pulse frame decoder.
// Holds gap window limits, sequencer step codes and the word types
// shared by the front, back and top-level files. No dependencies.
`timescale 1ns / 1ps

package ppfd_pkg;

  localparam int GAP_W  = 16;
  localparam int WORD_W = 16;
  localparam int CNT_W  = 5;

  // Gap windows in timer ticks, all bounds exclusive.
  localparam logic [GAP_W-1:0] SYNC_LO    = 16'd16;
  localparam logic [GAP_W-1:0] SYNC_HI    = 16'd20;
  localparam logic [GAP_W-1:0] LOW_LO     = 16'd41;
  localparam logic [GAP_W-1:0] LOW_HI     = 16'd46;
  localparam logic [GAP_W-1:0] PAUSE_LO   = 16'd82;
  localparam logic [GAP_W-1:0] PAUSE_HI   = 16'd90;
  localparam logic [GAP_W-1:0] ONE_LO     = 16'd10;
  localparam logic [GAP_W-1:0] ONE1_HI    = 16'd20;
  localparam logic [GAP_W-1:0] ONE2_HI    = 16'd22;
  localparam logic [GAP_W-1:0] ZERO_LO    = 16'd23;
  localparam logic [GAP_W-1:0] ZERO_HI    = 16'd33;
  localparam logic [GAP_W-1:0] SPLIT_LO   = 16'd172;
  localparam logic [GAP_W-1:0] SPLIT_HI   = 16'd212;
  localparam logic [GAP_W-1:0] ABORT_GAP  = 16'd200;

  // A sync run ends once its pulse count exceeds SYNC_DONE, a word once its bit count exceeds WORD_DONE.
  localparam logic [CNT_W-1:0] SYNC_DONE  = 5'd9;
  localparam logic [CNT_W-1:0] WORD_DONE  = 5'd15;

  typedef enum logic [3:0] {
    STEP_HUNT  = 4'd0,
    STEP_SYNC  = 4'd1,
    STEP_LOW   = 4'd2,
    STEP_PAUSE = 4'd3,
    STEP_WORD1 = 4'd4,
    STEP_SPLIT = 4'd5,
    STEP_WORD2 = 4'd6,
    STEP_DONE  = 4'd7,
    STEP_END   = 4'd8
  } step_t;

  // Classified word handed from front to back.
  typedef struct packed {
    logic ovf;
    logic pin;
    logic in_sync;
    logic in_low;
    logic in_pause;
    logic in_one1;
    logic in_one2;
    logic in_zero;
    logic in_split;
    logic abort;
  } item_t;

  // Result word delivered to the output side.
  typedef struct packed {
    logic              frame_ready;
    logic [WORD_W-1:0] first_word;
    logic [WORD_W-1:0] second_word;
    logic [3:0]        seq_step;
  } result_t;

  // Handshake between the front queue and the sequencer.
  typedef struct packed {
    logic  avail;
    item_t item;
  } mid_t;

endpackage

@@ hw/rtl/ppfd_front.sv @@
// Front of the decoder: accepts input words, classifies the gap into
// window flags and holds them in a two-entry queue for the back.
// Depends on ppfd_pkg.
`timescale 1ns / 1ps

module ppfd_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic                       mode,
  input  logic [ppfd_pkg::GAP_W-1:0] gap_ticks,
  input  logic                       pin_level,
  output ppfd_pkg::mid_t             mid,
  input  logic                       take
);

  ppfd_pkg::item_t item_in;
  ppfd_pkg::item_t mem [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      cnt;
  logic            do_push;
  logic            do_take;

  // Classify the gap against every window at once.
  always_comb begin
    item_in.ovf      = mode;
    item_in.pin      = pin_level;
    item_in.in_sync  = (gap_ticks > ppfd_pkg::SYNC_LO)  && (gap_ticks < ppfd_pkg::SYNC_HI);
    item_in.in_low   = (gap_ticks > ppfd_pkg::LOW_LO)   && (gap_ticks < ppfd_pkg::LOW_HI);
    item_in.in_pause = (gap_ticks > ppfd_pkg::PAUSE_LO) && (gap_ticks < ppfd_pkg::PAUSE_HI);
    item_in.in_one1  = (gap_ticks > ppfd_pkg::ONE_LO)   && (gap_ticks < ppfd_pkg::ONE1_HI);
    item_in.in_one2  = (gap_ticks > ppfd_pkg::ONE_LO)   && (gap_ticks < ppfd_pkg::ONE2_HI);
    item_in.in_zero  = (gap_ticks > ppfd_pkg::ZERO_LO)  && (gap_ticks < ppfd_pkg::ZERO_HI);
    item_in.in_split = (gap_ticks > ppfd_pkg::SPLIT_LO) && (gap_ticks < ppfd_pkg::SPLIT_HI);
    item_in.abort    = gap_ticks > ppfd_pkg::ABORT_GAP;
  end

  assign full      = (cnt == 2'd2);
  assign do_push   = push && !full;
  assign do_take   = take && (cnt != 2'd0);
  assign mid.avail = (cnt != 2'd0);
  assign mid.item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_take) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_take) begin
        cnt <= cnt + 2'd1;
      end else if (do_take && !do_push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

endmodule

@@ hw/rtl/ppfd_back.sv @@
// Back of the decoder: frame sequencer, bit counter and both words, plus
// a two-entry result queue toward the output side.
// Depends on ppfd_pkg.
`timescale 1ns / 1ps

module ppfd_back (
  input  logic                clk,
  input  logic                rst,
  input  ppfd_pkg::mid_t      mid,
  output logic                take,
  output logic                empty,
  input  logic                pop,
  output ppfd_pkg::result_t   res
);

  ppfd_pkg::step_t              step;
  ppfd_pkg::step_t              step_next;
  logic [ppfd_pkg::CNT_W-1:0]   bit_count;
  logic [ppfd_pkg::CNT_W-1:0]   bit_count_next;
  logic [ppfd_pkg::WORD_W-1:0]  word_one;
  logic [ppfd_pkg::WORD_W-1:0]  word_one_next;
  logic [ppfd_pkg::WORD_W-1:0]  word_two;
  logic [ppfd_pkg::WORD_W-1:0]  word_two_next;
  logic                         ready_next;

  // Shared bit-decode path for both word steps.
  logic [ppfd_pkg::WORD_W-1:0]  ws_word;
  logic [ppfd_pkg::CNT_W-1:0]   ws_cnt;
  ppfd_pkg::step_t              ws_step;
  logic                         ws_one;
  logic                         ws_fail;

  // Sync-run path.
  logic [ppfd_pkg::CNT_W-1:0]   sy_cnt;
  ppfd_pkg::step_t              sy_step;

  ppfd_pkg::result_t            mem [2];
  ppfd_pkg::result_t            res_in;
  logic                         wr_ptr;
  logic                         rd_ptr;
  logic [1:0]                   cnt;
  logic                         do_pop;

  assign empty  = (cnt == 2'd0);
  assign do_pop = pop && !empty;
  assign take   = mid.avail && ((cnt != 2'd2) || do_pop);
  assign res    = mem[rd_ptr];

  always_comb begin
    sy_cnt  = mid.item.in_sync ? bit_count + 5'd1 : bit_count;
    sy_step = mid.item.in_sync ? ppfd_pkg::STEP_SYNC : ppfd_pkg::STEP_HUNT;
    if (sy_cnt > ppfd_pkg::SYNC_DONE) begin
      sy_step = ppfd_pkg::step_t'(sy_step + 4'd1);
    end
  end

  always_comb begin
    ws_word = (step == ppfd_pkg::STEP_WORD2) ? word_two : word_one;
    ws_one  = (step == ppfd_pkg::STEP_WORD2) ? mid.item.in_one2 : mid.item.in_one1;
    ws_cnt  = bit_count;
    ws_fail = 1'b0;
    if (!mid.item.pin) begin
      priority if (ws_one) begin
        ws_word = ws_word | (16'd1 << bit_count[3:0]);
        ws_cnt  = bit_count + 5'd1;
      end else if (mid.item.in_zero) begin
        ws_cnt  = bit_count + 5'd1;
      end else begin
        ws_fail = 1'b1;
      end
    end
    ws_step = ws_fail ? ppfd_pkg::STEP_HUNT : step;
    if (ws_cnt > ppfd_pkg::WORD_DONE) begin
      ws_step = ppfd_pkg::step_t'(ws_step + 4'd1);
    end
    if (mid.item.abort) begin
      ws_step = ppfd_pkg::STEP_HUNT;
    end
  end

  always_comb begin
    step_next      = step;
    bit_count_next = bit_count;
    word_one_next  = word_one;
    word_two_next  = word_two;
    ready_next     = 1'b0;
    if (mid.item.ovf) begin
      step_next      = ppfd_pkg::STEP_HUNT;
      bit_count_next = '0;
    end else begin
      unique case (step)
        ppfd_pkg::STEP_HUNT: begin
          if (mid.item.pin) begin
            step_next      = ppfd_pkg::STEP_SYNC;
            bit_count_next = '0;
          end
        end
        ppfd_pkg::STEP_SYNC: begin
          step_next      = sy_step;
          bit_count_next = sy_cnt;
        end
        ppfd_pkg::STEP_LOW: begin
          step_next = (mid.item.in_low && !mid.item.pin) ? ppfd_pkg::STEP_PAUSE
                                                         : ppfd_pkg::STEP_HUNT;
        end
        ppfd_pkg::STEP_PAUSE: begin
          if (mid.item.in_pause && mid.item.pin) begin
            step_next      = ppfd_pkg::STEP_WORD1;
            bit_count_next = '0;
            word_one_next  = '0;
          end else begin
            step_next = ppfd_pkg::STEP_HUNT;
          end
        end
        ppfd_pkg::STEP_WORD1: begin
          step_next      = ws_step;
          bit_count_next = ws_cnt;
          word_one_next  = ws_word;
        end
        ppfd_pkg::STEP_SPLIT: begin
          if (mid.item.in_split && mid.item.pin) begin
            step_next      = ppfd_pkg::STEP_WORD2;
            bit_count_next = '0;
            word_two_next  = '0;
          end else begin
            step_next = ppfd_pkg::STEP_HUNT;
          end
        end
        ppfd_pkg::STEP_WORD2: begin
          step_next      = ws_step;
          bit_count_next = ws_cnt;
          word_two_next  = ws_word;
        end
        ppfd_pkg::STEP_DONE: begin
          ready_next = 1'b1;
          step_next  = ppfd_pkg::STEP_END;
        end
        default: begin
          step_next      = ppfd_pkg::STEP_HUNT;
          bit_count_next = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= ppfd_pkg::STEP_HUNT;
      bit_count <= '0;
      word_one  <= '0;
      word_two  <= '0;
    end else if (take) begin
      step      <= step_next;
      bit_count <= bit_count_next;
      word_one  <= word_one_next;
      word_two  <= word_two_next;
    end
  end

  always_comb begin
    res_in.frame_ready = ready_next;
    res_in.first_word  = word_one_next;
    res_in.second_word = word_two_next;
    res_in.seq_step    = step_next;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      mem[wr_ptr] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (take) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (take && !do_pop) begin
        cnt <= cnt + 2'd1;
      end else if (do_pop && !take) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

endmodule

@@ hw/rtl/park_pulse_frame_decoder.sv @@
// Top level of the parking-sensor pulse frame decoder.
// Instantiates ppfd_front and ppfd_back; depends on ppfd_pkg.
//
// Usage:
//   Input side is a queue write port: drive mode, gap_ticks and pin_level
//   and raise push; the word is taken at a clock edge with push high and
//   full low. mode=1 marks a gap counter overflow, which drops sync.
//   Result side is a queue read port: while empty is low the oldest result
//   (frame_ready, first_word, second_word, seq_step) is on the ports, and it
//   is taken at an edge with pop high and empty low. Every input word
//   yields exactly one result word.
// Timing:
//   A taken word is held in the front queue, then its result in the result
//   queue, before it can be popped. With pop held high one word per cycle
//   is sustained: the front classifies the gap combinationally into a
//   two-entry queue, the sequencer retires one word per cycle into another.
// Stall and reset:
//   When pop stays low the result queue fills, the sequencer holds, the
//   front queue fills and full rises; nothing is dropped.
//   rst (synchronous, active high) empties both queues, clears both words
//   and the bit count and puts the sequencer back to hunting for sync.
`timescale 1ns / 1ps

module park_pulse_frame_decoder (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic                        mode,
  input  logic [ppfd_pkg::GAP_W-1:0]  gap_ticks,
  input  logic                        pin_level,
  output logic                        empty,
  input  logic                        pop,
  output logic                        frame_ready,
  output logic [ppfd_pkg::WORD_W-1:0] first_word,
  output logic [ppfd_pkg::WORD_W-1:0] second_word,
  output logic [3:0]                  seq_step
);

  ppfd_pkg::mid_t    mid;
  ppfd_pkg::result_t res;
  logic              take;

  // Front: classify each incoming word and queue it.
  ppfd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .mode      (mode),
    .gap_ticks (gap_ticks),
    .pin_level (pin_level),
    .mid       (mid),
    .take      (take)
  );

  // Back: advance the frame sequencer and queue one result per word.
  ppfd_back u_back (
    .clk   (clk),
    .rst   (rst),
    .mid   (mid),
    .take  (take),
    .empty (empty),
    .pop   (pop),
    .res   (res)
  );

  assign frame_ready = res.frame_ready;
  assign first_word  = res.first_word;
  assign second_word = res.second_word;
  assign seq_step    = res.seq_step;

endmodule

@@ sim/tb_top.sv @@
// Self-checking bench for park_pulse_frame_decoder.
// Depends on ppfd_pkg (step codes, result word type) and the decoder RTL;
// stands alone otherwise: no files, no arguments.
`timescale 1ns / 1ps

module tb_top;

  // Gap windows of the sensor protocol, bounds exclusive, in timer ticks.
  localparam logic [15:0] SYNC_MIN  = 16'd16;
  localparam logic [15:0] SYNC_MAX  = 16'd20;
  localparam logic [15:0] LOW_MIN   = 16'd41;
  localparam logic [15:0] LOW_MAX   = 16'd46;
  localparam logic [15:0] PAUSE_MIN = 16'd82;
  localparam logic [15:0] PAUSE_MAX = 16'd90;
  localparam logic [15:0] ONE_MIN   = 16'd10;
  localparam logic [15:0] ONE1_MAX  = 16'd20;
  localparam logic [15:0] ONE2_MAX  = 16'd22;
  localparam logic [15:0] ZERO_MIN  = 16'd23;
  localparam logic [15:0] ZERO_MAX  = 16'd33;
  localparam logic [15:0] SPLIT_MIN = 16'd172;
  localparam logic [15:0] SPLIT_MAX = 16'd212;
  localparam logic [15:0] ABORT_MAX = 16'd200;

  // Sync pulses needed is SYNC_RUN_END + 1; a word holds WORD_END + 1 bits.
  localparam logic [4:0] SYNC_RUN_END = 5'd9;
  localparam logic [4:0] WORD_END     = 5'd15;

  localparam int RANDOM_WORDS = 740;
  localparam int STUCK_LIMIT  = 4000;  // cycles with no word moving on either side
  localparam int DRAIN_CYCLES = 20;    // tail after the last expected result
  localparam int SQUEEZE_AT   = 150;   // results seen before the long receiver hold
  localparam int SQUEEZE_LEN  = 150;

  // Gap values sitting on or next to every window bound, plus the extremes.
  localparam logic [15:0] GAP_CORNERS [28] = '{
    16'd0, 16'd10, 16'd11, 16'd16, 16'd17, 16'd19, 16'd20, 16'd21, 16'd22, 16'd23,
    16'd24, 16'd32, 16'd33, 16'd41, 16'd42, 16'd45, 16'd46, 16'd82, 16'd83, 16'd89,
    16'd90, 16'd172, 16'd173, 16'd200, 16'd201, 16'd211, 16'd212, 16'hFFFF
  };

  // One input word, plus a hand-typed expectation where the table gives one.
  typedef struct packed {
    logic              ovf;
    logic [15:0]       gap;
    logic              pin;
    logic              typed;
    ppfd_pkg::result_t res;
  } sensor_word_t;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic        mode;
  logic [15:0] gap_ticks;
  logic        pin_level;
  logic        empty;
  logic        pop;
  logic        frame_ready;
  logic [15:0] first_word;
  logic [15:0] second_word;
  logic [3:0]  seq_step;

  // Typed expectation of the word currently offered; stable from the falling edge.
  logic              cur_typed;
  ppfd_pkg::result_t cur_res;

  // Decoder state as the bench tracks it.
  logic [3:0]  trk_step;
  logic [4:0]  trk_count;
  logic [15:0] trk_word1;
  logic [15:0] trk_word2;

  sensor_word_t      sensor_q [$];
  sensor_word_t      frame_q [$];
  ppfd_pkg::result_t decoded_q [$];

  int results_out;
  int errors;
  int stuck;

  park_pulse_frame_decoder i_dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .mode        (mode),
    .gap_ticks   (gap_ticks),
    .pin_level   (pin_level),
    .empty       (empty),
    .pop         (pop),
    .frame_ready (frame_ready),
    .first_word  (first_word),
    .second_word (second_word),
    .seq_step    (seq_step)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Decode one bit of a word on a falling edge. A gap outside both windows
  // drops sync; the sixteenth bit advances the step; a long gap aborts.
  function automatic void take_word_bit(inout logic [15:0] w, input logic [15:0] g,
                                        input logic p, input logic [15:0] one_max);
    if (!p) begin
      if (g > ONE_MIN && g < one_max) begin
        w[trk_count[3:0]] = 1'b1;
        trk_count++;
      end else if (g > ZERO_MIN && g < ZERO_MAX) begin
        trk_count++;
      end else begin
        trk_step = ppfd_pkg::STEP_HUNT;
      end
    end
    if (trk_count > WORD_END) trk_step++;
    if (g > ABORT_MAX) trk_step = ppfd_pkg::STEP_HUNT;
  endfunction

  // Advance the tracked decoder by one input word and return the result word.
  function automatic ppfd_pkg::result_t frame_step(input logic ovf, input logic [15:0] g,
                                                   input logic p);
    ppfd_pkg::result_t r;
    r.frame_ready = 1'b0;
    if (ovf) begin
      // Counter overflow: drop sync, keep both words.
      trk_step  = ppfd_pkg::STEP_HUNT;
      trk_count = '0;
    end else begin
      unique case (trk_step)
        ppfd_pkg::STEP_HUNT: begin
          if (p) begin
            trk_step  = ppfd_pkg::STEP_SYNC;
            trk_count = '0;
          end
        end
        ppfd_pkg::STEP_SYNC: begin
          if (g > SYNC_MIN && g < SYNC_MAX) trk_count++;
          else trk_step = ppfd_pkg::STEP_HUNT;
          if (trk_count > SYNC_RUN_END) trk_step++;
        end
        ppfd_pkg::STEP_LOW: begin
          trk_step = (g > LOW_MIN && g < LOW_MAX && !p) ? ppfd_pkg::STEP_PAUSE
                                                        : ppfd_pkg::STEP_HUNT;
        end
        ppfd_pkg::STEP_PAUSE: begin
          if (g > PAUSE_MIN && g < PAUSE_MAX && p) begin
            trk_step  = ppfd_pkg::STEP_WORD1;
            trk_count = '0;
            trk_word1 = '0;
          end else begin
            trk_step = ppfd_pkg::STEP_HUNT;
          end
        end
        ppfd_pkg::STEP_WORD1: take_word_bit(trk_word1, g, p, ONE1_MAX);
        ppfd_pkg::STEP_SPLIT: begin
          if (g > SPLIT_MIN && g < SPLIT_MAX && p) begin
            trk_step  = ppfd_pkg::STEP_WORD2;
            trk_count = '0;
            trk_word2 = '0;
          end else begin
            trk_step = ppfd_pkg::STEP_HUNT;
          end
        end
        ppfd_pkg::STEP_WORD2: take_word_bit(trk_word2, g, p, ONE2_MAX);
        ppfd_pkg::STEP_DONE: begin
          r.frame_ready = 1'b1;
          trk_step      = ppfd_pkg::STEP_END;
        end
        default: begin
          // End step and the unreachable codes above it: back to hunting.
          trk_step  = ppfd_pkg::STEP_HUNT;
          trk_count = '0;
        end
      endcase
    end
    r.first_word  = trk_word1;
    r.second_word = trk_word2;
    r.seq_step    = trk_step;
    return r;
  endfunction

  function automatic sensor_word_t mk(input logic ovf, input logic [15:0] g, input logic p);
    sensor_word_t s;
    s       = '0;
    s.ovf   = ovf;
    s.gap   = g;
    s.pin   = p;
    return s;
  endfunction

  // Random word, biased toward window bounds; a tenth of them are overflows.
  function automatic sensor_word_t noise_word();
    int          r;
    logic [4:0]  pick;
    logic [15:0] g;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      pick = 5'($urandom_range(0, 27));
      g    = GAP_CORNERS[pick];
    end
    else if (r < 7) g = 16'($urandom_range(0, 255));
    else g = 16'($urandom);
    return mk($urandom_range(0, 9) == 0, g, 1'($urandom));
  endfunction

  // Length of the next idle stretch: mostly none or short, a few long,
  // and now and then a calm run with no idling at all.
  function automatic int draw_pause(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic put(input logic ovf, input logic [15:0] g, input logic p);
    frame_q.push_back(mk(ovf, g, p));
  endtask

  // Sixteen bits, LSB first, each a falling edge; most preceded by a rising
  // edge that may sit right at the abort bound.
  task automatic put_word(input logic [15:0] one_max);
    int          style;
    logic [15:0] bits;
    style = $urandom_range(0, 5);
    bits  = (style == 0) ? 16'hFFFF : (style == 1) ? 16'h0000 : 16'($urandom);
    for (int i = 0; i < 16; i++) begin
      if ($urandom_range(0, 9) < 7)
        put(1'b0, ($urandom_range(0, 9) == 0) ? ABORT_MAX : 16'($urandom_range(0, 200)), 1'b1);
      if (bits[i]) put(1'b0, 16'($urandom_range(ONE_MIN + 1, one_max - 1)), 1'b0);
      else put(1'b0, 16'($urandom_range(ZERO_MIN + 1, ZERO_MAX - 1)), 1'b0);
    end
  endtask

  // Queue one well-formed frame with random timing and content; when broken,
  // corrupt it at a random point: swap in noise, cut it short or drop an
  // overflow into it.
  task automatic add_frame(input bit broken);
    int k;
    frame_q.delete();
    put(1'b0, 16'($urandom), 1'b1);
    repeat (SYNC_RUN_END + 1) put(1'b0, 16'($urandom_range(SYNC_MIN + 1, SYNC_MAX - 1)),
                                  1'($urandom));
    put(1'b0, 16'($urandom_range(LOW_MIN + 1, LOW_MAX - 1)), 1'b0);
    put(1'b0, 16'($urandom_range(PAUSE_MIN + 1, PAUSE_MAX - 1)), 1'b1);
    put_word(ONE1_MAX);
    put(1'b0, 16'($urandom_range(SPLIT_MIN + 1, SPLIT_MAX - 1)), 1'b1);
    put_word(ONE2_MAX);
    put(1'b0, 16'($urandom), 1'($urandom));  // completes the frame
    put(1'b0, 16'($urandom), 1'($urandom));  // back to hunting
    if (broken) begin
      k = $urandom_range(0, frame_q.size() - 1);
      unique case ($urandom_range(0, 3))
        0, 1: frame_q[k] = noise_word();
        2: while (frame_q.size() > k + 1) void'(frame_q.pop_back());
        default: frame_q.insert(k, mk(1'b1, 16'($urandom), 1'($urandom)));
      endcase
    end
    foreach (frame_q[i]) sensor_q.push_back(frame_q[i]);
  endtask

  // Scoreboard: at each rising edge take in an accepted input word and
  // predict its result, then check a popped result against the oldest
  // prediction. Input is handled first so the order never depends on the
  // scheduler. The watchdog at the end ends a run that stops moving.
  always @(posedge clk) begin : score
    ppfd_pkg::result_t want;
    bit                moved;
    moved = 1'b0;
    if (!rst && push && !full) begin
      want = frame_step(mode, gap_ticks, pin_level);
      if (cur_typed) want = cur_res;
      decoded_q.push_back(want);
      moved = 1'b1;
    end
    if (!rst && pop && !empty) begin
      moved = 1'b1;
      results_out++;
      if (decoded_q.size() == 0) begin
        $error("result word with nothing expected: step %0d", seq_step);
        errors++;
      end else begin
        want = decoded_q.pop_front();
        if (frame_ready !== want.frame_ready) begin
          $error("frame_ready: expected %0d, got %0d", want.frame_ready, frame_ready);
          errors++;
        end
        if (first_word !== want.first_word) begin
          $error("first_word: expected %h, got %h", want.first_word, first_word);
          errors++;
        end
        if (second_word !== want.second_word) begin
          $error("second_word: expected %h, got %h", want.second_word, second_word);
          errors++;
        end
        if (seq_step !== want.seq_step) begin
          $error("seq_step: expected %0d, got %0d", want.seq_step, seq_step);
          errors++;
        end
      end
    end
    if (rst || moved) stuck = 0;
    else stuck++;
    if (stuck >= STUCK_LIMIT) begin
      $display("timeout: %0d cycles without a word moving", STUCK_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: random pop stalls at the falling edge, plus one long hold
  // that lets both queues fill so full has to rise against the sender.
  initial begin : receiver
    int calm;
    int hold;
    bit squeezed;
    pop      = 1'b0;
    calm     = 0;
    hold     = 0;
    squeezed = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold == 0 && !squeezed && results_out >= SQUEEZE_AT) begin
        squeezed = 1'b1;
        hold     = SQUEEZE_LEN;
      end else if (hold == 0) begin
        hold = draw_pause(calm);
      end
      if (hold != 0) begin
        pop <= 1'b0;
        hold--;
      end else begin
        pop <= 1'b1;
      end
      @(negedge clk);
    end
  end

  // Stimulus and run control.
  initial begin : sender
    sensor_word_t hand_rows [24];
    int           calm;
    int           pause;
    rst         = 1'b1;
    push        = 1'b0;
    mode        = 1'b0;
    gap_ticks   = '0;
    pin_level   = 1'b0;
    cur_typed   = 1'b0;
    cur_res     = '0;
    trk_step    = ppfd_pkg::STEP_HUNT;
    trk_count   = '0;
    trk_word1   = '0;
    trk_word2   = '0;
    results_out = 0;
    errors      = 0;
    stuck       = 0;
    calm        = 0;

    // Directed table: ovf, gap, pin, typed, {frame_ready, first, second, step}.
    // Rows with typed = 0 are checked against the tracked decoder.
    hand_rows = '{
      // overflow straight after reset: all clear
      '{1'b1, 16'hFFFF, 1'b1, 1'b1, '{1'b0, 16'h0000, 16'h0000, ppfd_pkg::STEP_HUNT}},
      // low level while hunting: stay
      '{1'b0, 16'h0000, 1'b0, 1'b1, '{1'b0, 16'h0000, 16'h0000, ppfd_pkg::STEP_HUNT}},
      // rising edge with the largest gap starts the sync run
      '{1'b0, 16'hFFFF, 1'b1, 1'b1, '{1'b0, 16'h0000, 16'h0000, ppfd_pkg::STEP_SYNC}},
      // sync gap on the upper bound drops sync
      '{1'b0, 16'd20,   1'b0, 1'b1, '{1'b0, 16'h0000, 16'h0000, ppfd_pkg::STEP_HUNT}},
      '{1'b0, 16'd16,   1'b1, 1'b1, '{1'b0, 16'h0000, 16'h0000, ppfd_pkg::STEP_SYNC}},
      '{1'b0, 16'd17,   1'b0, 1'b0, '0},
      // overflow in the middle of the sync run
      '{1'b1, 16'h0000, 1'b0, 1'b1, '{1'b0, 16'h0000, 16'h0000, ppfd_pkg::STEP_HUNT}},
      // full preamble: rising edge, ten sync gaps, low pulse, pause
      '{1'b0, 16'd5,    1'b1, 1'b0, '0},
      '{1'b0, 16'd17,   1'b0, 1'b0, '0},
      '{1'b0, 16'd18,   1'b1, 1'b0, '0},
      '{1'b0, 16'd19,   1'b0, 1'b0, '0},
      '{1'b0, 16'd17,   1'b1, 1'b0, '0},
      '{1'b0, 16'd18,   1'b0, 1'b0, '0},
      '{1'b0, 16'd19,   1'b1, 1'b0, '0},
      '{1'b0, 16'd17,   1'b0, 1'b0, '0},
      '{1'b0, 16'd18,   1'b1, 1'b0, '0},
      '{1'b0, 16'd19,   1'b0, 1'b0, '0},
      '{1'b0, 16'd17,   1'b1, 1'b0, '0},
      '{1'b0, 16'd42,   1'b0, 1'b0, '0},
      '{1'b0, 16'd89,   1'b1, 1'b0, '0},
      // shortest one-bit gap sets bit 0 of the first word
      '{1'b0, 16'd11,   1'b0, 1'b0, '0},
      // gap just over the abort bound on a rising edge: back to hunting
      '{1'b0, 16'd201,  1'b1, 1'b1, '{1'b0, 16'h0001, 16'h0000, ppfd_pkg::STEP_HUNT}},
      '{1'b0, 16'h0000, 1'b1, 1'b1, '{1'b0, 16'h0001, 16'h0000, ppfd_pkg::STEP_SYNC}},
      '{1'b1, 16'hFFFF, 1'b0, 1'b1, '{1'b0, 16'h0001, 16'h0000, ppfd_pkg::STEP_HUNT}}
    };
    foreach (hand_rows[i]) sensor_q.push_back(hand_rows[i]);

    // Random part: mostly frames, some of them broken, with noise between.
    while (sensor_q.size() < $size(hand_rows) + RANDOM_WORDS) begin
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 12)) sensor_q.push_back(noise_word());
      else add_frame($urandom_range(0, 9) < 3);
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Offer each word at a falling edge and hold it until it is taken.
    foreach (sensor_q[i]) begin
      pause = draw_pause(calm);
      if (pause != 0) begin
        push <= 1'b0;
        repeat (pause) @(negedge clk);
      end
      mode      <= sensor_q[i].ovf;
      gap_ticks <= sensor_q[i].gap;
      pin_level <= sensor_q[i].pin;
      cur_typed <= sensor_q[i].typed;
      cur_res   <= sensor_q[i].res;
      push      <= 1'b1;
      do @(posedge clk); while (full);
      @(negedge clk);
    end
    push <= 1'b0;

    // Drain every expected result, then give stray results a chance to show.
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
